>>> design/assert_macros.svh
// Assertion helper macros used by the detector core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error(msg);

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error(msg);

`endif

>>> design/dfd_pkg.sv
// ----------------------------------------------------------------------------
// dfd_pkg
// Types and constants of the destination flood detector.
// ----------------------------------------------------------------------------
package dfd_pkg;

  localparam logic [31:0] HASH_MULT    = 32'd2654435761;
  localparam logic [31:0] RATE_RST     = 32'd500;
  localparam logic [8:0]  DIV_RST      = 9'd1;
  localparam logic [31:0] RECOV_RST    = 32'd100;
  localparam logic [31:0] WINDOW_RST   = 32'd1000000;

  localparam logic [1:0] REG_RATE   = 2'd0;
  localparam logic [1:0] REG_DIV    = 2'd1;
  localparam logic [1:0] REG_RECOV  = 2'd2;
  localparam logic [1:0] REG_WINDOW = 2'd3;

  typedef struct packed {
    logic [31:0] dest_address;
    logic [15:0] dst_port;
    logic [31:0] source_address;
    logic [63:0] time_us;
  } dfd_in_t;

  typedef struct packed {
    logic under_attack;
    logic table_full;
  } dfd_out_t;

  // per-entry record kept in one memory word (bitmap kept separately)
  typedef struct packed {
    logic [63:0] window_begin;
    logic [31:0] packet_count;
    logic        attack_now;
    logic        attack_before;
  } dfd_entry_t;

endpackage

>>> design/destination_flood_detector_core.sv
// ----------------------------------------------------------------------------
// destination_flood_detector_core
// Per-destination flood detector with a memory-resident entry table.
// ----------------------------------------------------------------------------
// Usage: an item (destination address and port, source address, time in us)
// enters on in_valid/in_ready; exactly one result item (under_attack,
// table_full) leaves on out_valid/out_ready for each item, in order.
// Keys are held in flip-flops and matched combinationally. Entry state and the
// 256-bit source bitmap live in two single-port synchronous memories.
// Steps: hash and match, memory read, update and write back; the result
// register is loaded with the write back (in the read step for a new destination
// that finds the table full). One item is in work at a time, so the next item
// can enter only once the previous one has left the update step (the read step
// on a full table), as set by the read-modify-write of the entry memory.
// While a result waits, in_ready stays low unless the receiver takes that
// result in the same cycle; a stalled receiver holds the result and thereby
// holds off the input.
// Reset (synchronous, rst_n low) clears the fill count, the controller and
// restores register defaults; memories need no clearing, since stale contents
// are never used. Configuration writes take effect at once.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module destination_flood_detector_core #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dfd_pkg::dfd_in_t    in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dfd_pkg::dfd_out_t   out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import dfd_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MATCH = 4'b0010,
    ST_READ  = 4'b0100,
    ST_UPD   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [31:0] rate_r, recov_r, window_r;
  logic [8:0]  div_r;
  logic [CW-1:0] fill_r;

  logic [47:0] keys_r [TABLE_ENTRIES];
  dfd_entry_t  ent_mem [TABLE_ENTRIES];
  logic [255:0] bmp_mem [TABLE_ENTRIES];
  dfd_entry_t  ent_rd_r;
  logic [255:0] bmp_rd_r;

  dfd_in_t     item_r;
  logic [7:0]  bit_r;
  logic [IW-1:0] idx_r;
  logic        found_r, full_r;

  logic        res_valid_r;
  dfd_out_t    res_r;

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r   <= RATE_RST;
      div_r    <= DIV_RST;
      recov_r  <= RECOV_RST;
      window_r <= WINDOW_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RATE:   rate_r   <= cfg_data;
        REG_DIV:    div_r    <= cfg_data[8:0];
        REG_RECOV:  recov_r  <= cfg_data;
        REG_WINDOW: window_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // a new item enters only when the result slot is free or being drained
  assign in_ready = (state_r == ST_IDLE) && (!res_valid_r || out_ready);

  // match over stored keys
  logic [47:0]   key_w;
  logic          hit_w;
  logic [IW-1:0] hit_idx_w;
  logic [31:0]   hash_w;
  assign key_w  = {item_r.dest_address, item_r.dst_port};
  assign hash_w = item_r.source_address * HASH_MULT;

  always_comb begin
    hit_w     = 1'b0;
    hit_idx_w = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (CW'(i) < fill_r && keys_r[i] == key_w) begin
        hit_w     = 1'b1;
        hit_idx_w = IW'(i);
      end
    end
  end

  // update logic
  logic [63:0]  delta_w;
  logic         expired_w;
  logic [31:0]  cnt_inc_w;
  logic [255:0] bmp_set_w, bmp_one_w;
  logic [8:0]   pop_w;
  logic         hot_w;
  dfd_entry_t   ent_new_w;
  logic [255:0] bmp_new_w;
  logic         ans_w;

  assign delta_w   = item_r.time_us - ent_rd_r.window_begin;
  assign expired_w = delta_w > {32'd0, window_r};
  assign cnt_inc_w = (ent_rd_r.packet_count == '1) ? ent_rd_r.packet_count
                                                  : ent_rd_r.packet_count + 32'd1;
  assign bmp_one_w = 256'd1 << bit_r;
  assign bmp_set_w = bmp_rd_r | bmp_one_w;
  assign pop_w     = 9'($countones(bmp_set_w));
  assign hot_w     = (cnt_inc_w > rate_r) && (pop_w > div_r);

  always_comb begin
    ent_new_w = ent_rd_r;
    bmp_new_w = bmp_set_w;
    ans_w     = 1'b0;
    if (!found_r) begin
      ent_new_w = '{window_begin: item_r.time_us, packet_count: 32'd1,
                    attack_now: 1'b0, attack_before: 1'b0};
      bmp_new_w = bmp_one_w;
    end else if (expired_w) begin
      ent_new_w = '{window_begin: item_r.time_us, packet_count: 32'd1,
                    attack_now: 1'b0, attack_before: ent_rd_r.attack_now};
      bmp_new_w = bmp_one_w;
      ans_w     = ent_rd_r.attack_now;
    end else begin
      ent_new_w.packet_count = cnt_inc_w;
      if (hot_w) begin
        ent_new_w.attack_now = 1'b1;
        ans_w = 1'b1;
      end else begin
        if (ent_rd_r.attack_before && cnt_inc_w > recov_r) ent_new_w.attack_now = 1'b1;
        ans_w = ent_new_w.attack_now | ent_rd_r.attack_before;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid && in_ready) state_nxt = ST_MATCH;
      ST_MATCH: state_nxt = ST_READ;
      ST_READ:  state_nxt = full_r ? ST_IDLE : ST_UPD;
      ST_UPD:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_MATCH && !hit_w && fill_r != CW'(TABLE_ENTRIES))
        fill_r <= fill_r + CW'(1);
      if ((state_r == ST_READ && full_r) || state_r == ST_UPD) res_valid_r <= 1'b1;
      else if (res_valid_r && out_ready) res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid && in_ready) item_r <= in_data;
    if (state_r == ST_MATCH) begin
      bit_r   <= hash_w[31:24];
      found_r <= hit_w;
      full_r  <= !hit_w && (fill_r == CW'(TABLE_ENTRIES));
      idx_r   <= hit_w ? hit_idx_w : fill_r[IW-1:0];
      if (!hit_w && fill_r != CW'(TABLE_ENTRIES)) keys_r[fill_r[IW-1:0]] <= key_w;
    end
    if (state_r == ST_READ && full_r) res_r <= '{under_attack: 1'b0, table_full: 1'b1};
    if (state_r == ST_UPD) res_r <= '{under_attack: ans_w, table_full: 1'b0};
  end

  // entry memories: read in ST_READ, write back in ST_UPD
  always_ff @(posedge clk) begin
    if (state_r == ST_UPD) begin
      ent_mem[idx_r] <= ent_new_w;
      bmp_mem[idx_r] <= bmp_new_w;
    end
    if (state_r == ST_READ) begin
      ent_rd_r <= ent_mem[idx_r];
      bmp_rd_r <= bmp_mem[idx_r];
    end
  end

  assign out_valid = res_valid_r;
  assign out_data  = res_r;

  `ASSERT_IMPL(a_fill_bound, clk, rst_n, 1'b1, fill_r <= CW'(TABLE_ENTRIES),
               "fill count beyond table size")
  `ASSERT_IMPL(a_no_accept_busy, clk, rst_n, state_r != ST_IDLE, !in_ready,
               "item accepted while busy")
  `ASSERT_NEXT(a_upd_result, clk, rst_n, state_r == ST_UPD, out_valid && !out_data.table_full,
               "update did not produce a result")

endmodule
